/* hdl/prefix_block_rule_table_assert.svh */
// assertion macros for the prefix block rule table datapath
// no dependencies; included by pbrt_dp, which checks its own logic
`ifndef PREFIX_BLOCK_RULE_TABLE_ASSERT_SVH
`define PREFIX_BLOCK_RULE_TABLE_ASSERT_SVH

// property that holds at every clock edge out of reset
`define PBRT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define PBRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pbrt_pkg.sv */
// types and constants of the prefix block rule table
// no dependencies; used by pbrt_ctrl, pbrt_dp and the top level
package pbrt_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // rule directions above this value match every query direction
    localparam logic [7:0] DIR_ANY_MIN = 8'h01;

    // lengths up to this value always have a trie node
    localparam logic [5:0] LEN_ROOT_MAX = 6'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic read;
        logic decide;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

/* hdl/pbrt_ctrl.sv */
// controller of the prefix block rule table: sequences accept, scan, decide, output
// depends on pbrt_pkg
module pbrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_opcode,
    input  pbrt_pkg::t_stat  i_stat,
    output logic             o_stall,
    output pbrt_pkg::t_cmd   o_cmd
);

    pbrt_pkg::t_state r_state;
    pbrt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            pbrt_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_opcode == pbrt_pkg::OP_NOP || i_stat.empty) begin
                        n_state = pbrt_pkg::ST_DECIDE;
                    end else begin
                        n_state = pbrt_pkg::ST_SCAN;
                    end
                end
            end
            pbrt_pkg::ST_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = pbrt_pkg::ST_DRAIN;
                end
            end
            pbrt_pkg::ST_DRAIN: begin
                n_state = pbrt_pkg::ST_DECIDE;
            end
            pbrt_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = pbrt_pkg::ST_FINISH;
            end
            pbrt_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pbrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/pbrt_dp.sv */
// datapath of the prefix block rule table: rule memory, scan compare, result register
// depends on pbrt_pkg and prefix_block_rule_table_assert.svh
`include "prefix_block_rule_table_assert.svh"

module pbrt_dp #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbrt_pkg::t_cmd   i_cmd,
    input  logic [1:0]       i_opcode,
    input  logic [31:0]      i_key,
    input  logic [5:0]       i_prefix_length,
    input  logic [7:0]       i_direction,
    input  logic             i_stall,
    output pbrt_pkg::t_stat  o_stat,
    output logic             o_valid,
    output logic             o_status,
    output logic             o_is_blocked
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] prefix;
        logic [5:0]          len;
        logic [7:0]          dir;
        logic                blocked;
    } t_entry;

    // mask of the low n bits of a key word
    function automatic logic [KEY_BITS-1:0] f_mask(input logic [5:0] n);
        logic [KEY_BITS-1:0] ones;
        ones = '1;
        return ~(ones << n);
    endfunction

    t_entry              mem [ENTRIES];

    // latched operation
    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_key_low;
    logic [5:0]          r_len;
    logic [7:0]          r_dir;

    // scan pointer and fill count (entries 0 to count-1 are in use)
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    // registered read word
    t_entry              r_rd;
    logic [AW-1:0]       r_rd_idx;
    logic                r_cmp_valid;

    // scan results
    logic                r_found;
    logic [AW-1:0]       r_found_idx;
    logic [7:0]          r_found_dir;
    logic                r_exists;
    logic                r_hit;

    // decision result and output word
    logic                r_res_status;
    logic                r_res_hit;
    logic                n_res_status;
    logic                n_res_hit;
    logic                r_out_valid;
    logic                r_out_status;
    logic                r_out_hit;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic                w_full;
    logic                w_exact;
    logic                w_covers;
    logic                w_dir_hit;
    logic                w_blocks;

    assign w_full = (r_count == CW'(ENTRIES));

    // status to the controller
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.scan_last = ((CW'(r_addr) + CW'(1)) == r_count);
    assign o_stat.out_free  = !r_out_valid || !i_stall;

    // compare of the word read in the previous cycle
    always_comb begin
        w_exact   = (r_rd.len == r_len) && (r_rd.prefix == r_key_low);
        w_covers  = (r_rd.len >= r_len) && ((r_rd.prefix & f_mask(r_len)) == r_key_low);
        w_dir_hit = (r_rd.dir == r_dir) || (r_rd.dir > pbrt_pkg::DIR_ANY_MIN);
        if (r_rd.len == '0) begin
            w_blocks = (r_len == '0);
        end else begin
            w_blocks = (r_rd.len <= r_len) && (r_rd.prefix == (r_key & f_mask(r_rd.len)));
        end
        w_blocks = w_blocks && r_rd.blocked && w_dir_hit;
    end

    // operand latch and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_opcode;
            r_key     <= i_key[KEY_BITS-1:0];
            r_key_low <= i_key[KEY_BITS-1:0] & f_mask(i_prefix_length);
            r_len     <= i_prefix_length;
            r_dir     <= i_direction;
            r_addr    <= '0;
        end else if (i_cmd.read) begin
            r_addr    <= r_addr + AW'(1);
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd     <= mem[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.read;
        end
    end

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_found  <= 1'b0;
            r_exists <= 1'b0;
            r_hit    <= 1'b0;
        end else if (r_cmp_valid) begin
            if (w_exact && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= r_rd_idx;
                r_found_dir <= r_rd.dir;
            end
            r_exists <= r_exists || w_covers;
            r_hit    <= r_hit || w_blocks;
        end
    end

    // decision: table write and result
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_found_idx;
        w_wdata      = '{prefix: r_key_low, len: r_len, dir: r_dir, blocked: 1'b1};
        n_count      = r_count;
        n_res_status = 1'b0;
        n_res_hit    = 1'b0;
        if (i_cmd.decide) begin
            unique case (r_op)
                pbrt_pkg::OP_INSERT: begin
                    if (r_found) begin
                        w_we = 1'b1;
                    end else if (!w_full) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end else begin
                        n_res_status = 1'b1;
                    end
                end
                pbrt_pkg::OP_REMOVE: begin
                    if (!(r_len <= pbrt_pkg::LEN_ROOT_MAX || r_exists)) begin
                        n_res_status = 1'b1;
                    end else if (r_found) begin
                        w_we    = 1'b1;
                        w_wdata = '{prefix: r_key_low, len: r_len, dir: r_found_dir,
                                    blocked: 1'b0};
                    end
                end
                pbrt_pkg::OP_CHECK: begin
                    n_res_hit = r_hit;
                end
                default: begin
                end
            endcase
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_status <= n_res_status;
            r_res_hit    <= n_res_hit;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_hit    <= r_res_hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_is_blocked = r_out_hit;

    // checks
    `PBRT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "fill count beyond table size")
    `PBRT_ASSERT_IMPL(a_read_in_use, i_clk, i_rst_n, i_cmd.read, CW'(r_addr) < r_count, "scan reads an unused entry")
    `PBRT_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, i_cmd.load_out, !r_out_valid || !i_stall, "output word overwritten while held")
    `PBRT_ASSERT_NEXT(a_count_on_decide, i_clk, i_rst_n, i_rst_n && !i_cmd.decide, $stable(r_count), "fill count changed outside decision")

endmodule

/* hdl/prefix_block_rule_table.sv */
// Prefix block rule table: insert, remove and check of LSB-first prefix rules.
// Each word runs IDLE (accept), SCAN over the N entries in use (0 to ENTRIES), DRAIN,
// DECIDE and FINISH; an unused opcode or an empty table goes from IDLE to DECIDE.
// FINISH waits while the previous result is stalled; the scan reads one entry per cycle.
// Synchronous active-low reset empties the table (fill count) and drops any held result.
// depends on pbrt_pkg, pbrt_ctrl, pbrt_dp
module prefix_block_rule_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_key,
    input  logic [5:0]  i_prefix_length,
    input  logic [7:0]  i_direction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic        o_is_blocked
);

    pbrt_pkg::t_cmd  w_cmd;
    pbrt_pkg::t_stat w_stat;

    // sequencer
    pbrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    // rule memory and compare
    pbrt_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_opcode),
        .i_key           (i_key),
        .i_prefix_length (i_prefix_length),
        .i_direction     (i_direction),
        .i_stall         (i_stall),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_is_blocked    (o_is_blocked)
    );

endmodule

/* sim/tb_prefix_block_rule_table.sv */
// self-checking testbench for the prefix block rule table: directed words, then random phases
// with sender idling and receiver stalls, every result compared with a built-in rule predictor
// depends on pbrt_pkg and prefix_block_rule_table
module tb_prefix_block_rule_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 64;
    localparam int KEY_BITS    = 32;
    localparam int PHASE_WORDS = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_KEYS   = 6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
        logic [5:0]  plen;
        logic [7:0]  dir;
    } t_rule_word;

    typedef struct packed {
        logic status;
        logic is_blocked;
    } t_rule_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = pbrt_pkg::OP_NOP;
    logic [31:0] i_key = '0;
    logic [5:0]  i_prefix_length = '0;
    logic [7:0]  i_direction = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_status;
    logic        o_is_blocked;

    // mirror of the rule table
    logic [31:0] mir_prefix  [ENTRIES];
    logic [5:0]  mir_len     [ENTRIES];
    logic [7:0]  mir_dir     [ENTRIES];
    logic        mir_blocked [ENTRIES];
    logic        mir_valid   [ENTRIES];

    t_rule_word  word_queue[$];
    t_rule_resp  resp_due[$];
    logic [31:0] key_pool [POOL_KEYS];
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          n_fail = 0;
    int          n_cycles = 0;

    prefix_block_rule_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_key           (i_key),
        .i_prefix_length (i_prefix_length),
        .i_direction     (i_direction),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_is_blocked    (o_is_blocked)
    );

    always #4 i_clk = ~i_clk;

    // low min(len, KEY_BITS) bits of a value
    function automatic logic [31:0] low_bits(logic [31:0] v, int unsigned len);
        int unsigned n;
        n = (len < KEY_BITS) ? len : KEY_BITS;
        if (n >= 32) return v;
        return v & ((32'h1 << n) - 32'h1);
    endfunction

    function automatic int find_rule(logic [31:0] key, logic [5:0] len);
        for (int i = 0; i < ENTRIES; i++) begin
            if (mir_valid[i] && mir_len[i] == len && mir_prefix[i] == low_bits(key, len))
                return i;
        end
        return -1;
    endfunction

    // trie node on the key's path at depth len
    function automatic bit path_present(logic [31:0] key, logic [5:0] len);
        if (len <= pbrt_pkg::LEN_ROOT_MAX) return 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (mir_valid[i] && mir_len[i] >= len &&
                low_bits(mir_prefix[i], len) == low_bits(key, len))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one word to the mirror and return the result it produces
    function automatic t_rule_resp rule_table_apply(t_rule_word w);
        t_rule_resp  r;
        logic [31:0] key;
        int          e;
        r   = '0;
        key = low_bits(w.key, KEY_BITS);
        case (w.opcode)
            pbrt_pkg::OP_INSERT: begin
                e = find_rule(key, w.plen);
                if (e < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!mir_valid[i]) begin
                            e = i;
                            break;
                        end
                    end
                    if (e >= 0) begin
                        mir_valid[e]  = 1'b1;
                        mir_prefix[e] = low_bits(key, w.plen);
                        mir_len[e]    = w.plen;
                    end
                end
                if (e < 0) begin
                    r.status = 1'b1;
                end else begin
                    mir_blocked[e] = 1'b1;
                    mir_dir[e]     = w.dir;
                end
            end
            pbrt_pkg::OP_REMOVE: begin
                if (!path_present(key, w.plen)) begin
                    r.status = 1'b1;
                end else begin
                    e = find_rule(key, w.plen);
                    if (e >= 0) mir_blocked[e] = 1'b0;
                end
            end
            pbrt_pkg::OP_CHECK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (mir_valid[i] && mir_blocked[i] &&
                        (mir_dir[i] == w.dir || mir_dir[i] > pbrt_pkg::DIR_ANY_MIN)) begin
                        if (mir_len[i] == 0) begin
                            if (w.plen == 0) r.is_blocked = 1'b1;
                        end else if (mir_len[i] <= w.plen &&
                                     mir_prefix[i] == low_bits(key, mir_len[i])) begin
                            r.is_blocked = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // random word: mostly keys near a small pool so rules overlap and hit
    function automatic t_rule_word random_word();
        t_rule_word w;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 35)      w.opcode = pbrt_pkg::OP_INSERT;
        else if (r < 55) w.opcode = pbrt_pkg::OP_REMOVE;
        else if (r < 97) w.opcode = pbrt_pkg::OP_CHECK;
        else             w.opcode = pbrt_pkg::OP_NOP;
        if ($urandom_range(0, 99) < 80)
            w.key = key_pool[$urandom_range(0, POOL_KEYS - 1)]
                    ^ ($urandom << $urandom_range(0, 32));
        else
            w.key = $urandom;
        r = $urandom_range(0, 99);
        if (r < 10)      w.plen = 6'd0;
        else if (r < 20) w.plen = 6'd32;
        else if (w.opcode == pbrt_pkg::OP_CHECK && r < 60)
            w.plen = 6'($urandom_range(0, 32));
        else
            w.plen = 6'($urandom_range(1, 12));
        r = $urandom_range(0, 99);
        if (r < 60)      w.dir = 8'($urandom_range(0, 1));
        else if (r < 80) w.dir = 8'($urandom_range(2, 255));
        else             w.dir = 8'($urandom);
        return w;
    endfunction

    task automatic push_word(logic [1:0] op, logic [31:0] key, logic [5:0] len,
                             logic [7:0] dir);
        t_rule_word w;
        w.opcode = op;
        w.key    = key;
        w.plen   = len;
        w.dir    = dir;
        word_queue.push_back(w);
    endtask

    // wait until the sender has nothing left and every result has come
    task automatic drain_phase();
        while (word_queue.size() != 0 || i_valid || resp_due.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: predict each accepted word, then present the next one or idle
    always @(posedge i_clk) begin : drive_proc
        t_rule_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                w = {i_opcode, i_key, i_prefix_length, i_direction};
                resp_due.push_back(rule_table_apply(w));
            end
            if (!i_valid || !o_stall) begin
                if (word_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    w = word_queue.pop_front();
                    i_opcode        <= w.opcode;
                    i_key           <= w.key;
                    i_prefix_length <= w.plen;
                    i_direction     <= w.dir;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : watch_proc
        t_rule_resp r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (resp_due.size() == 0) begin
                    $error("unexpected result word: status %0d is_blocked %0d",
                           o_status, o_is_blocked);
                    n_fail++;
                end else begin
                    r = resp_due.pop_front();
                    if (o_status !== r.status) begin
                        $error("status mismatch: expected %0d actual %0d", r.status, o_status);
                        n_fail++;
                    end
                    if (o_is_blocked !== r.is_blocked) begin
                        $error("is_blocked mismatch: expected %0d actual %0d",
                               r.is_blocked, o_is_blocked);
                        n_fail++;
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stim_proc
        int sender_pct [4];
        int recv_pct   [4];
        sender_pct = '{0, 54, 0, 14};
        recv_pct   = '{0, 0, 54, 14};
        for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = $urandom;
        // empty mirror, as after reset
        for (int i = 0; i < ENTRIES; i++) begin
            mir_valid[i]   = 1'b0;
            mir_blocked[i] = 1'b0;
            mir_prefix[i]  = '0;
            mir_len[i]     = '0;
            mir_dir[i]     = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: root depths exist, deeper paths do not
        push_word(pbrt_pkg::OP_CHECK,  32'h0000_0000, 6'd0,  8'd0);
        push_word(pbrt_pkg::OP_REMOVE, 32'h0000_0000, 6'd0,  8'd0);
        push_word(pbrt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 6'd1,  8'd255);
        push_word(pbrt_pkg::OP_REMOVE, 32'h1234_5678, 6'd2,  8'd0);
        push_word(pbrt_pkg::OP_NOP,    32'hFFFF_FFFF, 6'd32, 8'd255);
        // length-zero rule only hits depth-zero checks of its direction
        push_word(pbrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0,  8'd0);
        push_word(pbrt_pkg::OP_CHECK,  32'h0000_0000, 6'd0,  8'd0);
        push_word(pbrt_pkg::OP_CHECK,  32'h0000_0000, 6'd5,  8'd0);
        push_word(pbrt_pkg::OP_CHECK,  32'hFFFF_FFFF, 6'd0,  8'd1);
        // full-width rule with a wildcard direction
        push_word(pbrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd255);
        push_word(pbrt_pkg::OP_CHECK,  32'hFFFF_FFFF, 6'd32, 8'd7);
        push_word(pbrt_pkg::OP_CHECK,  32'hFFFF_FFFF, 6'd31, 8'd7);
        // short rule, direction match, then re-insert with a wildcard direction
        push_word(pbrt_pkg::OP_INSERT, 32'h0000_0005, 6'd3,  8'd1);
        push_word(pbrt_pkg::OP_CHECK,  32'hABCD_0005, 6'd8,  8'd1);
        push_word(pbrt_pkg::OP_CHECK,  32'hABCD_0005, 6'd8,  8'd0);
        push_word(pbrt_pkg::OP_INSERT, 32'h0000_0005, 6'd3,  8'd2);
        push_word(pbrt_pkg::OP_CHECK,  32'hABCD_0005, 6'd8,  8'd0);
        // remove of a node that was never a rule leaves the rule blocked
        push_word(pbrt_pkg::OP_REMOVE, 32'h0000_0005, 6'd2,  8'd0);
        push_word(pbrt_pkg::OP_CHECK,  32'h0000_000D, 6'd4,  8'd1);
        push_word(pbrt_pkg::OP_REMOVE, 32'h0000_0005, 6'd3,  8'd0);
        push_word(pbrt_pkg::OP_CHECK,  32'hABCD_0005, 6'd8,  8'd0);
        push_word(pbrt_pkg::OP_REMOVE, 32'h0000_0002, 6'd3,  8'd0);
        push_word(pbrt_pkg::OP_NOP,    32'h0000_0000, 6'd0,  8'd0);
        drain_phase();

        // random phases; each ends by waiting until the sender has nothing left and all results are in
        for (int p = 0; p < 4; p++) begin
            idle_pct  = sender_pct[p];
            stall_pct = recv_pct[p];
            for (int n = 0; n < PHASE_WORDS; n++) word_queue.push_back(random_word());
            drain_phase();
        end
        stall_pct = 0;

        repeat (100) @(negedge i_clk);
        if (n_fail == 0 && resp_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/pbrt_pkg.sv
hdl/pbrt_ctrl.sv
hdl/pbrt_dp.sv
hdl/prefix_block_rule_table.sv
sim/tb_prefix_block_rule_table.sv
